@@ sv/bbc_pkg.sv @@
package bbc_pkg;

	localparam int STACK_DEPTH_DEF = 64;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;
	localparam logic [7:0] CH_LCURLY = 8'h7B;
	localparam logic [7:0] CH_RCURLY = 8'h7D;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	localparam logic MODE_END = 1'b1;

	typedef enum logic [2:0] {
		VERDICT_OK        = 3'd0,
		VERDICT_OPEN      = 3'd1,
		VERDICT_MISMATCH  = 3'd2,
		VERDICT_UNDERFLOW = 3'd3,
		VERDICT_OVERFLOW  = 3'd4
	} verdict_t;

	typedef enum logic [1:0] {
		KIND_ROUND  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// classified transaction handed from front to back
	typedef struct packed {
		logic  end_mark;
		logic  is_nl;
		logic  is_quote;
		logic  is_open;
		logic  is_close;
		kind_t kind;
	} item_t;

endpackage

@@ sv/bbc_if.sv @@
interface bbc_text_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] ch;

	modport source (output valid, output mode, output ch, input ready);
	modport sink (input valid, input mode, input ch, output ready);
endinterface

interface bbc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [31:0] line_count;
	logic [31:0] char_count;
	logic [6:0]  open_depth;

	modport source (output valid, output verdict, output line_count, output char_count,
		output open_depth, input ready);
	modport sink (input valid, input verdict, input line_count, input char_count,
		input open_depth, output ready);
endinterface

@@ sv/bbc_ram.sv @@
module bbc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ sv/bbc_front.sv @@
module bbc_front (
	input  logic           clk,
	input  logic           arst_n,
	bbc_text_if.sink       text,
	output logic           item_valid,
	output bbc_pkg::item_t item,
	input  logic           item_ready
);
	import bbc_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t cls;

	always_comb begin
		cls          = '0;
		cls.end_mark = (text.mode == MODE_END);
		cls.is_nl    = (text.ch == CH_NEWLINE);
		cls.is_quote = (text.ch == CH_QUOTE);
		cls.kind     = KIND_NONE;
		case (text.ch)
			CH_LPAREN: begin
				cls.is_open = 1'b1;
				cls.kind    = KIND_ROUND;
			end
			CH_LSQUARE: begin
				cls.is_open = 1'b1;
				cls.kind    = KIND_SQUARE;
			end
			CH_LCURLY: begin
				cls.is_open = 1'b1;
				cls.kind    = KIND_CURLY;
			end
			CH_RPAREN: begin
				cls.is_close = 1'b1;
				cls.kind     = KIND_ROUND;
			end
			CH_RSQUARE: begin
				cls.is_close = 1'b1;
				cls.kind     = KIND_SQUARE;
			end
			CH_RCURLY: begin
				cls.is_close = 1'b1;
				cls.kind     = KIND_CURLY;
			end
			default: begin
				cls.kind = KIND_NONE;
			end
		endcase
	end

	assign text.ready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			item_s1 <= cls;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;
endmodule

@@ sv/bbc_queue.sv @@
module bbc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  bbc_pkg::item_t push_item,
	output logic           push_ready,
	output logic           pop_valid,
	output bbc_pkg::item_t pop_item,
	input  logic           pop_ready
);
	import bbc_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end
endmodule

@@ sv/bbc_back.sv @@
module bbc_back #(
	parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  bbc_pkg::item_t item,
	output logic           item_ready,
	bbc_result_if.source   result
);
	import bbc_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

	logic [DW-1:0] depth_q;
	logic [DW-1:0] depth_n;
	logic [31:0]   lines_q;
	logic [31:0]   chars_q;
	logic          prior_quote_q;
	logic [1:0]    phase_q;
	verdict_t      err_q;
	kind_t         tos_q;
	kind_t         byp_q;
	logic          byp_sel_q;
	logic          out_valid_q;

	logic          out_free;
	logic          fire;
	logic          run;
	logic [1:0]    phase_adv;
	logic          examine;
	logic          push;
	logic          pop;
	logic [1:0]    ram_rdata;
	kind_t         nos;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	verdict_t      verdict_n;

	assign out_free   = !out_valid_q || result.ready;
	assign item_ready = !item.end_mark || out_free;
	assign fire       = item_valid && item_ready;
	// character that still counts: no error latched yet
	assign run        = fire && !item.end_mark && (err_q == VERDICT_OK);

	assign phase_adv = (prior_quote_q && !item.is_quote) ? phase_q + 2'd1 : phase_q;
	assign examine   = (phase_adv == 2'd0) || (phase_adv == 2'd2);
	assign push      = run && examine && item.is_open && (depth_q != DEPTH_FULL);
	assign pop       = run && examine && item.is_close && (depth_q != '0);

	always_comb begin
		depth_n = depth_q;
		if (fire && item.end_mark) begin
			depth_n = '0;
		end else if (push) begin
			depth_n = depth_q + DW'(1);
		end else if (pop) begin
			depth_n = depth_q - DW'(1);
		end
	end

	// second entry from the top, prefetched for the next pop
	assign raddr = AW'(depth_n - DW'(2));
	assign waddr = AW'(depth_q - DW'(1));
	assign nos   = byp_sel_q ? byp_q : kind_t'(ram_rdata);

	bbc_ram #(
		.WIDTH(2),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (push && (depth_q != '0)),
		.waddr(waddr),
		.wdata(tos_q),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		verdict_n = err_q;
		if (err_q == VERDICT_OK && depth_q != '0) begin
			verdict_n = VERDICT_OPEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q       <= '0;
			lines_q       <= 32'd1;
			chars_q       <= '0;
			prior_quote_q <= 1'b0;
			phase_q       <= '0;
			err_q         <= VERDICT_OK;
			byp_sel_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			depth_q   <= depth_n;
			byp_sel_q <= push;
			if (out_free) begin
				out_valid_q <= fire && item.end_mark;
			end
			if (fire && item.end_mark) begin
				lines_q       <= 32'd1;
				chars_q       <= '0;
				prior_quote_q <= 1'b0;
				phase_q       <= '0;
				err_q         <= VERDICT_OK;
			end else if (run) begin
				if (item.is_nl && lines_q != '1) begin
					lines_q <= lines_q + 32'd1;
				end
				if (chars_q != '1) begin
					chars_q <= chars_q + 32'd1;
				end
				phase_q       <= (phase_adv == 2'd2) ? 2'd0 : phase_adv;
				prior_quote_q <= item.is_quote;
				if (examine && item.is_open && depth_q == DEPTH_FULL) begin
					err_q <= VERDICT_OVERFLOW;
				end else if (examine && item.is_close && depth_q == '0) begin
					err_q <= VERDICT_UNDERFLOW;
				end else if (pop && tos_q != item.kind) begin
					err_q <= VERDICT_MISMATCH;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			tos_q <= item.kind;
			byp_q <= tos_q;
		end else if (pop) begin
			tos_q <= nos;
		end
		if (fire && item.end_mark) begin
			result.verdict    <= verdict_n;
			result.line_count <= lines_q;
			result.char_count <= chars_q;
			result.open_depth <= (32'(depth_q) > 32'd127) ? 7'd127 : 7'(depth_q);
		end
	end

	assign result.valid = out_valid_q;
endmodule

@@ sv/bracket_balance_checker.sv @@
// Bracket balance checker.
// text channel: one byte per transaction (mode 0) or an end marker (mode 1).
// result channel: one transaction per end marker with the verdict, the line and
// character counts, and the number of openers still open.
// Characters give no result; one is accepted every cycle unless stalled.
// A classify stage feeds a two-entry queue; the back end does one push or pop
// at the stack top per cycle, with the top kept in a register and the entry
// below prefetched from the stack RAM, so there is no pop-to-pop bubble.
// An end marker passes the classify register, the queue and the result output
// register before it shows on result.
// If result stalls, the pending result holds in its output register; the back
// end stops only at the next end marker, and the queue and classify stage then
// fill and drop text.ready.
// Reset (arst_n low) clears counts, error, stack depth and both channels; the
// stack RAM itself is not cleared, only entries below the depth are read.
// After an error all bytes up to the end marker are ignored; the end marker
// reports and clears all state.
module bracket_balance_checker #(
	parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bbc_text_if.sink     text,
	bbc_result_if.source result
);
	import bbc_pkg::*;

	logic  f_valid;
	item_t f_item;
	logic  f_ready;
	logic  b_valid;
	item_t b_item;
	logic  b_ready;

	bbc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.item_valid(f_valid),
		.item      (f_item),
		.item_ready(f_ready)
	);

	bbc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_item (f_item),
		.push_ready(f_ready),
		.pop_valid (b_valid),
		.pop_item  (b_item),
		.pop_ready (b_ready)
	);

	bbc_back #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(b_valid),
		.item      (b_item),
		.item_ready(b_ready),
		.result    (result)
	);
endmodule

@@ dv/tb_bracket_balance_checker.sv @@
`timescale 1ns / 100ps

module tb_bracket_balance_checker;
	import bbc_pkg::*;

	localparam logic MODE_CHAR = 1'b0;

	typedef struct {
		logic [2:0]  verdict;
		logic [31:0] lines;
		logic [31:0] chars;
		logic [6:0]  depth;
	} tally_t;

	logic clk;
	logic arst_n;
	bit   quiet;
	bit   gaps_on;

	bbc_text_if   text_ch ();
	bbc_result_if result_ch ();

	bracket_balance_checker DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch)
	);

	function automatic kind_t opener_of(logic [7:0] c);
		case (c)
			CH_LPAREN:  return KIND_ROUND;
			CH_LSQUARE: return KIND_SQUARE;
			CH_LCURLY:  return KIND_CURLY;
			default:    return KIND_NONE;
		endcase
	endfunction

	function automatic kind_t closer_of(logic [7:0] c);
		case (c)
			CH_RPAREN:  return KIND_ROUND;
			CH_RSQUARE: return KIND_SQUARE;
			CH_RCURLY:  return KIND_CURLY;
			default:    return KIND_NONE;
		endcase
	endfunction

	// tracks nesting, counts and quote state; holds the verdicts still owed
	class nesting_scoreboard;
		kind_t       kinds [STACK_DEPTH_DEF];
		int unsigned depth;
		logic [31:0] lines;
		logic [31:0] chars;
		bit          after_quote;
		logic [1:0]  phase;
		logic [2:0]  fault;
		tally_t      due [$];
		int          failures;
		int          live_chars;
		int          tallies_seen;

		function new();
			failures     = 0;
			live_chars   = 0;
			tallies_seen = 0;
			clear();
		endfunction

		function void clear();
			depth       = 0;
			lines       = 32'd1;
			chars       = '0;
			after_quote = 1'b0;
			phase       = 2'd0;
			fault       = VERDICT_OK;
		endfunction

		function logic [31:0] bump(logic [31:0] v);
			return (v == '1) ? v : v + 32'd1;
		endfunction

		function void apply_bracket(logic [7:0] c);
			kind_t k;
			k = opener_of(c);
			if (k != KIND_NONE) begin
				if (depth >= STACK_DEPTH_DEF) begin
					fault = VERDICT_OVERFLOW;
				end else begin
					kinds[depth] = k;
					depth++;
				end
			end else begin
				k = closer_of(c);
				if (k != KIND_NONE) begin
					if (depth == 0) begin
						fault = VERDICT_UNDERFLOW;
					end else begin
						// top is popped even when it does not match
						depth--;
						if (kinds[depth] != k)
							fault = VERDICT_MISMATCH;
					end
				end
			end
		endfunction

		function void note_text(logic mode, logic [7:0] c);
			tally_t t;
			if (mode == MODE_END) begin
				t.verdict = (fault == VERDICT_OK && depth != 0) ? VERDICT_OPEN : fault;
				t.lines   = lines;
				t.chars   = chars;
				t.depth   = 7'(depth);
				due.push_back(t);
				clear();
				return;
			end
			if (fault != VERDICT_OK)
				return;
			live_chars++;
			if (c == CH_NEWLINE)
				lines = bump(lines);
			chars = bump(chars);
			if (after_quote && c != CH_QUOTE)
				phase = phase + 2'd1;
			if (phase == 2'd0 || phase == 2'd2) begin
				apply_bracket(c);
				if (phase == 2'd2)
					phase = 2'd0;
			end
			after_quote = (c == CH_QUOTE);
		endfunction

		function void check_field(string what, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				failures++;
				$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			end
		endfunction

		function void check_result(tally_t got);
			tally_t want;
			tallies_seen++;
			if (due.size() == 0) begin
				failures++;
				$display("%0t: unexpected result: verdict %0d lines %0d chars %0d depth %0d",
					$time, got.verdict, got.lines, got.chars, got.depth);
				return;
			end
			want = due.pop_front();
			check_field("verdict", 32'(want.verdict), 32'(got.verdict));
			check_field("line_count", want.lines, got.lines);
			check_field("char_count", want.chars, got.chars);
			check_field("open_depth", 32'(want.depth), 32'(got.depth));
		endfunction
	endclass

	nesting_scoreboard sb = new();

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && text_ch.valid && text_ch.ready)
			sb.note_text(text_ch.mode, text_ch.ch);
	end

	always @(posedge clk) begin
		tally_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.verdict = result_ch.verdict;
			got.lines   = result_ch.line_count;
			got.chars   = result_ch.char_count;
			got.depth   = result_ch.open_depth;
			sb.check_result(got);
		end
	end

	// result backpressure: stall bursts separated by calm stretches
	initial begin
		int stall_left;
		int calm_left;
		stall_left = 0;
		calm_left  = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_ch.ready = 1'b0;
				stall_left--;
			end else if (calm_left > 0 || quiet) begin
				result_ch.ready = 1'b1;
				if (calm_left > 0)
					calm_left--;
			end else if ($urandom_range(0, 3) == 0) begin
				result_ch.ready = 1'b0;
				stall_left = $urandom_range(1, 7) - 1;
				calm_left  = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80) : 0;
			end else begin
				result_ch.ready = 1'b1;
			end
		end
	end

	function automatic logic [7:0] open_char(kind_t k);
		case (k)
			KIND_ROUND:  return CH_LPAREN;
			KIND_SQUARE: return CH_LSQUARE;
			default:     return CH_LCURLY;
		endcase
	endfunction

	function automatic logic [7:0] close_char(kind_t k);
		case (k)
			KIND_ROUND:  return CH_RPAREN;
			KIND_SQUARE: return CH_RSQUARE;
			default:     return CH_RCURLY;
		endcase
	endfunction

	function automatic kind_t any_kind();
		return kind_t'($urandom_range(0, 2));
	endfunction

	// plain text byte, now and then a newline
	function automatic logic [7:0] filler();
		logic [7:0] c;
		if ($urandom_range(0, 7) == 0)
			return CH_NEWLINE;
		c = 8'($urandom_range(0, 255));
		while (opener_of(c) != KIND_NONE || closer_of(c) != KIND_NONE || c == CH_QUOTE)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 3))
			0: return open_char(any_kind());
			1: return close_char(any_kind());
			2: return CH_QUOTE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void build_nest(ref logic [7:0] q[$], input int max_nest,
		input int steps, input bit close_all);
		kind_t open_kinds [$];
		kind_t k;
		int    pick;
		repeat (steps) begin
			pick = $urandom_range(0, 9);
			if (pick < 4 && open_kinds.size() < max_nest) begin
				k = any_kind();
				open_kinds.push_back(k);
				q.push_back(open_char(k));
			end else if (pick < 7 && open_kinds.size() > 0) begin
				q.push_back(close_char(open_kinds.pop_back()));
			end else if (pick == 7) begin
				// bracket inside a character literal
				q.push_back(CH_QUOTE);
				q.push_back($urandom_range(0, 1) ? open_char(any_kind()) : close_char(any_kind()));
				q.push_back(CH_QUOTE);
			end else begin
				q.push_back(filler());
			end
		end
		if (close_all)
			while (open_kinds.size() > 0)
				q.push_back(close_char(open_kinds.pop_back()));
	endfunction

	function automatic void build_deep(ref logic [7:0] q[$], input int n, input bit close_all);
		kind_t open_kinds [$];
		kind_t k;
		repeat (n) begin
			k = any_kind();
			open_kinds.push_back(k);
			q.push_back(open_char(k));
			if ($urandom_range(0, 5) == 0)
				q.push_back(filler());
		end
		if (close_all)
			while (open_kinds.size() > 0) begin
				q.push_back(close_char(open_kinds.pop_back()));
				if ($urandom_range(0, 5) == 0)
					q.push_back(filler());
			end
	endfunction

	// bytes after an error are ignored by the block
	function automatic void add_trail(ref logic [7:0] q[$]);
		repeat ($urandom_range(0, 4))
			q.push_back(noise_byte());
	endfunction

	task automatic send_item(input logic m, input logic [7:0] c);
		if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
			text_ch.valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		text_ch.valid = 1'b1;
		text_ch.mode  = m;
		text_ch.ch    = c;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic play(input logic [7:0] q[$]);
		foreach (q[i])
			send_item(MODE_CHAR, q[i]);
		send_item(MODE_END, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		logic [7:0] q [$];
		kind_t      k;
		int         pick;
		int         round;
		int         guard;

		text_ch.valid = 1'b0;
		text_ch.mode  = MODE_CHAR;
		text_ch.ch    = 8'h00;
		quiet         = 1'b0;
		gaps_on       = 1'b0;
		arst_n        = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty text, clean nesting with byte extremes, mismatch,
		// closer on empty stack, quoted bracket, unclosed opener
		q = {};
		play(q);
		q = '{CH_LPAREN, CH_LSQUARE, 8'h00, CH_LCURLY, CH_RCURLY, CH_RSQUARE, 8'hFF, CH_RPAREN};
		play(q);
		q = '{CH_LCURLY, CH_RPAREN, CH_LPAREN};
		play(q);
		q = '{CH_RSQUARE, CH_NEWLINE};
		play(q);
		gaps_on = 1'b1;
		q = '{CH_LPAREN, CH_QUOTE, CH_RCURLY, CH_QUOTE, CH_RPAREN};
		play(q);
		q = '{CH_LSQUARE, CH_NEWLINE};
		play(q);

		round = 0;
		while (sb.live_chars < 1500 || sb.tallies_seen < 40) begin
			q = {};
			gaps_on = ($urandom_range(0, 3) != 0);
			pick = (round == 0) ? 17 : (round == 1) ? 21 : $urandom_range(0, 19);
			if (pick <= 10) begin
				if ($urandom_range(0, 7) == 0)
					build_deep(q, $urandom_range(20, 64), 1'b1);
				else
					build_nest(q, $urandom_range(1, 8), $urandom_range(0, 40), 1'b1);
			end else if (pick <= 13) begin
				build_nest(q, $urandom_range(1, 8), $urandom_range(1, 40), 1'b0);
			end else if (pick <= 15) begin
				build_nest(q, $urandom_range(1, 6), $urandom_range(0, 20), 1'b1);
				k = any_kind();
				q.push_back(open_char(k));
				q.push_back(close_char(kind_t'((int'(k) + $urandom_range(1, 2)) % 3)));
				add_trail(q);
			end else if (pick == 16) begin
				build_nest(q, $urandom_range(1, 6), $urandom_range(0, 20), 1'b1);
				q.push_back(close_char(any_kind()));
				add_trail(q);
			end else if (pick == 17) begin
				build_deep(q, (round == 0) ? 65 : $urandom_range(60, 66),
					1'($urandom_range(0, 1)));
				add_trail(q);
			end else if (pick <= 19) begin
				repeat ($urandom_range(0, 30))
					q.push_back(noise_byte());
			end else begin
				// stack filled to the last entry, then unwound
				build_deep(q, STACK_DEPTH_DEF, 1'b1);
			end
			play(q);
			round++;
			if (sb.live_chars >= 1300)
				quiet = 1'b1;
		end
		text_ch.valid = 1'b0;

		guard = 0;
		while (sb.due.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (sb.failures == 0 && sb.due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
